[sv/flic_delta_chunk_decoder_macros.svh]
// ---------------------------------------------------------------------------
// FLIC chunk decoder assertion macros
// Concurrent assertion shorthands on clk_i / rst_ni, used by the back end.
// ---------------------------------------------------------------------------
`ifndef FLIC_DELTA_CHUNK_DECODER_MACROS_SVH
`define FLIC_DELTA_CHUNK_DECODER_MACROS_SVH

// same-cycle implication
`define FLIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FLIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/flic_dcd_pkg.sv]
// ---------------------------------------------------------------------------
// FLIC chunk decoder package
// Word types, request codes, register map and defaults.
// ---------------------------------------------------------------------------
package flic_dcd_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RST_WIDTH      = 320;
  localparam int RST_HEIGHT     = 200;
  localparam int CFG_W          = 11;
  localparam int FRAME_W        = 22;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_BRUN = 2'd1,
    REQ_LC   = 2'd2,
    REQ_SS2  = 2'd3
  } req_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [19:0] write_addr;
    logic [8:0]  write_len;
    logic [15:0] write_value;
    logic        word_pattern;
    logic        chunk_done;
    logic        overrun;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic       is_begin;
    req_e       kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

[sv/flic_dcd_front.sv]
// ---------------------------------------------------------------------------
// FLIC chunk decoder front end
// Classifies incoming words and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module flic_dcd_front import flic_dcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  output q_head_t  head_o,
  input  logic     pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cls;

  always_comb begin
    cls.is_begin = (in_word_i.req_type != REQ_BYTE);
    cls.kind     = req_e'(in_word_i.req_type);
    cls.data     = in_word_i.data_byte;
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

[sv/flic_dcd_back.sv]
// ---------------------------------------------------------------------------
// FLIC chunk decoder back end
// Chunk parser state machine, position tracking and the output register.
// ---------------------------------------------------------------------------
module flic_dcd_back import flic_dcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_head_t            head_i,
  output logic               pop_o,
  input  logic [CFG_W-1:0]   eff_w_i,
  input  logic [CFG_W-1:0]   eff_h_i,
  input  logic [FRAME_W-1:0] frame_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_word_t          out_word_o
);

  `include "flic_delta_chunk_decoder_macros.svh"

  typedef enum logic [4:0] {
    PH_IDLE, PH_BR_LINE, PH_BR_COUNT, PH_BR_FILL, PH_BR_LIT,
    PH_LC_START_LO, PH_LC_START_HI, PH_LC_LINES_LO, PH_LC_LINES_HI,
    PH_LC_PKTS, PH_LC_SKIP, PH_LC_SIZE, PH_LC_FILL, PH_LC_LIT,
    PH_S2_LINES_LO, PH_S2_LINES_HI, PH_S2_OP_LO, PH_S2_OP_HI,
    PH_S2_SKIP, PH_S2_SIZE, PH_S2_PAT_LO, PH_S2_PAT_HI, PH_S2_LIT
  } phase_e;

  phase_e      ph_q, ph_d, end_nxt;
  logic [20:0] base_q, base_d, base_add;
  logic [16:0] off_q, off_d, off_add;
  logic [15:0] lines_q, lines_d, pkts_q, pkts_d;
  logic [8:0]  bytes_q, bytes_d;
  logic [7:0]  held_q, held_d;
  logic        out_valid_q;
  out_word_t   out_q, res;

  logic        go;
  logic [7:0]  b, mag;
  logic        neg;
  logic [15:0] hw;
  logic        use_mul, use_last;
  logic [16:0] mul_a;
  logic [27:0] mul, base_inc;
  logic [28:0] base_sum;
  logic [8:0]  off_inc;
  logic [17:0] off_sum;
  logic [21:0] e_off, e_addr;
  logic [22:0] e_end;
  logic        emit, done, do_end, pkt_done, br_chk;
  logic [8:0]  e_len;
  logic [15:0] e_val;
  logic        e_pat;

  assign go    = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = go;
  assign b     = head_i.cmd.data;
  assign neg   = b[7];
  assign mag   = neg ? (8'd0 - b) : b;
  assign hw    = {b, held_q};

  // shared position arithmetic
  assign use_mul  = (ph_q == PH_LC_START_HI) || ((ph_q == PH_S2_OP_HI) && hw[15] && hw[14]);
  assign use_last = (ph_q == PH_S2_OP_HI);
  assign mul_a    = (ph_q == PH_LC_START_HI) ? {1'b0, hw} : (17'h10000 - {1'b0, hw});
  assign mul      = 28'(mul_a) * 28'(eff_w_i);
  assign base_inc = use_mul ? mul : 28'(eff_w_i);
  assign base_sum = {8'd0, base_q} + {1'b0, base_inc};
  assign base_add = (base_sum > 29'h1FFFFF) ? '1 : base_sum[20:0];

  always_comb begin
    unique case (ph_q)
      PH_BR_LIT, PH_LC_LIT, PH_S2_LIT:      off_inc = 9'd1;
      PH_LC_SKIP, PH_S2_SKIP:               off_inc = {1'b0, b};
      default:                              off_inc = bytes_q;
    endcase
  end
  assign off_sum = {1'b0, off_q} + {9'd0, off_inc};
  assign off_add = off_sum[17] ? '1 : off_sum[16:0];

  // emitted write position and frame bound check
  assign e_off  = use_last ? ((eff_w_i != '0) ? 22'(eff_w_i - 1'b1) : 22'd0) : 22'(off_q);
  assign e_addr = 22'(base_q) + e_off;
  assign e_end  = {1'b0, e_addr} + 23'(e_len);

  always_comb begin
    ph_d     = ph_q;
    base_d   = base_q;
    off_d    = off_q;
    lines_d  = lines_q;
    pkts_d   = pkts_q;
    bytes_d  = bytes_q;
    held_d   = held_q;
    emit     = 1'b0;
    done     = 1'b0;
    do_end   = 1'b0;
    pkt_done = 1'b0;
    br_chk   = 1'b0;
    end_nxt  = PH_IDLE;
    e_len    = '0;
    e_val    = '0;
    e_pat    = 1'b0;

    if (head_i.cmd.is_begin) begin
      base_d  = '0;
      off_d   = '0;
      lines_d = '0;
      pkts_d  = '0;
      bytes_d = '0;
      held_d  = '0;
      unique case (head_i.cmd.kind)
        REQ_BRUN: begin
          lines_d = 16'(eff_h_i);
          if (eff_h_i == '0) begin
            done = 1'b1;
            ph_d = PH_IDLE;
          end else begin
            ph_d = PH_BR_LINE;
          end
        end
        REQ_LC:  ph_d = PH_LC_START_LO;
        default: ph_d = PH_S2_LINES_LO;
      endcase
    end else begin
      unique case (ph_q)
        PH_BR_LINE: begin
          if (eff_w_i == '0) begin
            do_end  = 1'b1;
            end_nxt = PH_BR_LINE;
          end else begin
            ph_d = PH_BR_COUNT;
          end
        end
        PH_BR_COUNT: begin
          if (b != 8'd0) begin
            bytes_d = {1'b0, mag};
            ph_d    = neg ? PH_BR_LIT : PH_BR_FILL;
          end
        end
        PH_BR_FILL: begin
          emit   = 1'b1;
          e_len  = bytes_q;
          e_val  = {8'd0, b};
          off_d  = off_add;
          br_chk = 1'b1;
        end
        PH_BR_LIT: begin
          emit    = 1'b1;
          e_len   = 9'd1;
          e_val   = {8'd0, b};
          off_d   = off_add;
          bytes_d = bytes_q - 9'd1;
          br_chk  = (bytes_q == 9'd1);
        end
        PH_LC_START_LO: begin
          held_d = b;
          ph_d   = PH_LC_START_HI;
        end
        PH_LC_START_HI: begin
          base_d = base_add;
          ph_d   = PH_LC_LINES_LO;
        end
        PH_LC_LINES_LO, PH_S2_LINES_LO: begin
          held_d = b;
          ph_d   = (ph_q == PH_LC_LINES_LO) ? PH_LC_LINES_HI : PH_S2_LINES_HI;
        end
        PH_LC_LINES_HI, PH_S2_LINES_HI: begin
          lines_d = hw;
          if (hw == 16'd0) begin
            done = 1'b1;
            ph_d = PH_IDLE;
          end else begin
            ph_d = (ph_q == PH_LC_LINES_HI) ? PH_LC_PKTS : PH_S2_OP_LO;
          end
        end
        PH_LC_PKTS: begin
          pkts_d = {8'd0, b};
          off_d  = '0;
          if (b == 8'd0) begin
            do_end  = 1'b1;
            end_nxt = PH_LC_PKTS;
          end else begin
            ph_d = PH_LC_SKIP;
          end
        end
        PH_LC_SKIP, PH_S2_SKIP: begin
          off_d = off_add;
          ph_d  = (ph_q == PH_LC_SKIP) ? PH_LC_SIZE : PH_S2_SIZE;
        end
        PH_LC_SIZE: begin
          if (b == 8'd0) begin
            pkt_done = 1'b1;
          end else begin
            bytes_d = {1'b0, mag};
            ph_d    = neg ? PH_LC_FILL : PH_LC_LIT;
          end
        end
        PH_LC_FILL: begin
          emit     = 1'b1;
          e_len    = bytes_q;
          e_val    = {8'd0, b};
          off_d    = off_add;
          pkt_done = 1'b1;
        end
        PH_LC_LIT, PH_S2_LIT: begin
          emit     = 1'b1;
          e_len    = 9'd1;
          e_val    = {8'd0, b};
          off_d    = off_add;
          bytes_d  = bytes_q - 9'd1;
          pkt_done = (bytes_q == 9'd1);
        end
        PH_S2_OP_LO: begin
          held_d = b;
          ph_d   = PH_S2_OP_HI;
        end
        PH_S2_OP_HI: begin
          if (!hw[15]) begin
            // packet count closes the opcodes of this line
            pkts_d = hw;
            off_d  = '0;
            if (hw == 16'd0) begin
              do_end  = 1'b1;
              end_nxt = PH_S2_OP_LO;
            end else begin
              ph_d = PH_S2_SKIP;
            end
          end else if (hw[14]) begin
            base_d = base_add;
            ph_d   = PH_S2_OP_LO;
          end else begin
            // last pixel of the line, same line continues
            emit  = 1'b1;
            e_len = 9'd1;
            e_val = {8'd0, held_q};
            ph_d  = PH_S2_OP_LO;
          end
        end
        PH_S2_SIZE: begin
          if (b == 8'd0) begin
            pkt_done = 1'b1;
          end else begin
            bytes_d = {mag, 1'b0};
            ph_d    = neg ? PH_S2_PAT_LO : PH_S2_LIT;
          end
        end
        PH_S2_PAT_LO: begin
          held_d = b;
          ph_d   = PH_S2_PAT_HI;
        end
        PH_S2_PAT_HI: begin
          emit     = 1'b1;
          e_len    = bytes_q;
          e_val    = hw;
          e_pat    = 1'b1;
          off_d    = off_add;
          pkt_done = 1'b1;
        end
        default: ph_d = PH_IDLE;
      endcase

      if (br_chk) begin
        if (off_add >= 17'(eff_w_i)) begin
          do_end  = 1'b1;
          end_nxt = PH_BR_LINE;
        end else begin
          ph_d = PH_BR_COUNT;
        end
      end

      if (pkt_done) begin
        pkts_d = pkts_q - 16'd1;
        if (pkts_q == 16'd1) begin
          do_end  = 1'b1;
          end_nxt = (ph_q == PH_LC_SIZE || ph_q == PH_LC_FILL || ph_q == PH_LC_LIT) ?
                    PH_LC_PKTS : PH_S2_OP_LO;
        end else begin
          ph_d = (ph_q == PH_LC_SIZE || ph_q == PH_LC_FILL || ph_q == PH_LC_LIT) ?
                 PH_LC_SKIP : PH_S2_SKIP;
        end
      end

      if (do_end) begin
        lines_d = lines_q - 16'd1;
        base_d  = base_add;
        off_d   = '0;
        if (lines_q == 16'd1) begin
          done = 1'b1;
          ph_d = PH_IDLE;
        end else begin
          ph_d = end_nxt;
        end
      end
    end
  end

  always_comb begin
    res              = '0;
    res.chunk_done   = done;
    if (emit) begin
      res.write_addr   = e_addr[19:0];
      res.write_len    = e_len;
      res.write_value  = e_val;
      res.word_pattern = e_pat;
      res.overrun      = (e_end > 23'(frame_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      base_q      <= '0;
      off_q       <= '0;
      lines_q     <= '0;
      pkts_q      <= '0;
      bytes_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        ph_q        <= ph_d;
        base_q      <= base_d;
        off_q       <= off_d;
        lines_q     <= lines_d;
        pkts_q      <= pkts_d;
        bytes_q     <= bytes_d;
        held_q      <= held_d;
        out_valid_q <= emit || done;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `FLIC_ASSERT_NOW(a_idle_quiet,
    go && !head_i.cmd.is_begin && ph_q == PH_IDLE, !emit && !done,
    "payload in idle produced a result")
  `FLIC_ASSERT_NOW(a_marker_done,
    out_valid_q && out_q.write_len == 9'd0, out_q.chunk_done && !out_q.overrun,
    "empty write that is not a done marker")
  `FLIC_ASSERT_NOW(a_pat_even,
    out_valid_q && out_q.word_pattern, out_q.write_len[0] == 1'b0,
    "word fill of odd length")
  `FLIC_ASSERT_NXT(a_done_idle,
    go && done, ph_q == PH_IDLE,
    "chunk finished but parser not idle")

endmodule

[sv/flic_delta_chunk_decoder.sv]
// ---------------------------------------------------------------------------
// FLIC delta chunk decoder
// Top level: register port, front queue and back parser.
// ---------------------------------------------------------------------------
// Turns BRUN, LC and SS2 chunk payload bytes into frame-buffer write words,
// one input word per clock when the result side is not stalled. A begin word
// picks the chunk kind; every payload byte then moves the parser on and may
// give one result: a byte fill, a word-pattern fill or one literal byte, with
// its address and length. The result of a chunk's last byte has chunk_done
// set; a write reaching past width*height has overrun set and must be
// dropped. A word is held in the two-entry front queue, passes the parser
// and its result is registered in the output register; the queue and the
// output register let either side stall alone. Frame width and height sit
// at byte addresses 0 and 4 and should only change while the decoder is
// idle.
// ---------------------------------------------------------------------------
module flic_delta_chunk_decoder import flic_dcd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0]   width_q, height_q, eff_w, eff_h;
  logic [FRAME_W-1:0] frame;
  logic               wr_en;
  q_head_t            head;
  logic               pop;

  // register port: paddr[2] selects the register
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_WIDTH: prdata = {21'd0, width_q};
      default:   prdata = {21'd0, height_q};
    endcase
  end

  // values beyond the build limits are taken as the limits
  assign eff_w = (32'(width_q)  > MAX_WIDTH)  ? CFG_W'(MAX_WIDTH)  : width_q;
  assign eff_h = (32'(height_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_q;

  // frame size follows the registers in the same cycle
  assign frame = FRAME_W'(eff_w) * FRAME_W'(eff_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(RST_WIDTH);
      height_q <= CFG_W'(RST_HEIGHT);
    end else begin
      if (wr_en) begin
        if (reg_e'(paddr[2]) == REG_WIDTH) begin
          width_q <= pwdata[CFG_W-1:0];
        end else begin
          height_q <= pwdata[CFG_W-1:0];
        end
      end
    end
  end

  flic_dcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  flic_dcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .eff_w_i     (eff_w),
    .eff_h_i     (eff_h),
    .frame_i     (frame),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
